// File: src/lge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 40;
	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int GEN_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [1:0] {
		OP_STEP = 2'd0,
		OP_TOGGLE = 2'd1,
		OP_READ = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		WR_ZERO,
		WR_LIFE,
		WR_FLIP
	} wr_src_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic rd_sweep;
		logic sweep_inc;
		logic we;
		wr_src_t wr_src;
		logic fill;
		logic advance;
		logic gen_inc;
		logic alive_set;
		logic out_load;
	} lge_cmd_t;

	typedef struct packed {
		op_t op;
		logic oor;
		logic nr_zero;
		logic clr_last;
		logic row_last;
		logic out_free;
	} lge_sts_t;

	// Next state of one cell from its 3x3 neighborhood; mid[1] is the cell itself.
	function automatic logic life_next(input logic [2:0] up, input logic [2:0] mid,
			input logic [2:0] dn);
		logic [3:0] cnt;
		begin
			cnt = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
				+ 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
			return (cnt == BIRTH_COUNT) || (mid[1] && (cnt == SURVIVE_COUNT));
		end
	endfunction

endpackage

`default_nettype wire

// File: src/lge_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lge_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire lge_pkg::lge_sts_t sts,
	output lge_pkg::lge_cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_DECODE,
		ST_FILL,
		ST_RUN,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.wr_src = lge_pkg::WR_ZERO;
		state_nx = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.we = 1'b1;
				cmd.wr_src = lge_pkg::WR_ZERO;
				cmd.sweep_inc = 1'b1;
				if (sts.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nx = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.op)
					lge_pkg::OP_STEP: begin
						cmd.gen_inc = 1'b1;
						if (sts.nr_zero) begin
							state_nx = ST_DONE;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sweep = 1'b1;
							cmd.sweep_inc = 1'b1;
							state_nx = ST_FILL;
						end
					end
					lge_pkg::OP_TOGGLE, lge_pkg::OP_READ: begin
						if (sts.oor) begin
							state_nx = ST_DONE;
						end else begin
							cmd.rd_en = 1'b1;
							state_nx = ST_ACC;
						end
					end
					default: begin
						state_nx = ST_DONE;
					end
				endcase
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sweep = 1'b1;
				cmd.sweep_inc = 1'b1;
				state_nx = ST_RUN;
			end
			ST_RUN: begin
				cmd.we = 1'b1;
				cmd.wr_src = lge_pkg::WR_LIFE;
				cmd.advance = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sweep = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (sts.row_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_ACC: begin
				cmd.alive_set = 1'b1;
				if (sts.op == lge_pkg::OP_TOGGLE) begin
					cmd.we = 1'b1;
					cmd.wr_src = lge_pkg::WR_FLIP;
				end
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/lge_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lge_dp #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lge_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic [1:0]                    in_cmd,
	input  wire logic [lge_pkg::ROW_W-1:0]     in_row,
	input  wire logic [lge_pkg::COL_W-1:0]     in_col,
	input  wire lge_pkg::lge_cmd_t             cmd,
	output lge_pkg::lge_sts_t                  sts,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	output logic                               out_alive,
	output logic [lge_pkg::GEN_W-1:0]          out_gen,
	output logic                               out_oor
);

	localparam int NRW = ($clog2(MAX_ROWS + 1) > lge_pkg::CFG_W) ?
		$clog2(MAX_ROWS + 1) : lge_pkg::CFG_W;
	localparam int NCW = ($clog2(MAX_COLS + 1) > lge_pkg::CFG_W) ?
		$clog2(MAX_COLS + 1) : lge_pkg::CFG_W;
	localparam int CW = NRW + 1;
	localparam int RAW = $clog2(MAX_ROWS);
	localparam int CAW = $clog2(MAX_COLS);

	logic [lge_pkg::CFG_W-1:0] rows_cfg_q;
	logic [lge_pkg::CFG_W-1:0] cols_cfg_q;
	logic [NRW-1:0] rows_ext;
	logic [NCW-1:0] cols_ext;
	logic [NRW-1:0] nr;
	logic [NCW-1:0] nc;

	lge_pkg::op_t op_q;
	logic [lge_pkg::ROW_W-1:0] row_q;
	logic [lge_pkg::COL_W-1:0] col_q;
	logic [NRW-1:0] row_ext;
	logic [NCW-1:0] col_ext;
	logic [RAW-1:0] row_idx;
	logic [CAW-1:0] col_idx;

	logic [CW-1:0] sweep_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] cur_nx;
	logic [CW-1:0] nr_c;

	logic [lge_pkg::GEN_W-1:0] gen_q;
	logic alive_q;
	logic m_valid_q;
	logic oor;

	logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rdata_q;
	logic [MAX_COLS-1:0] above_q;
	logic [MAX_COLS-1:0] here_q;
	logic [MAX_COLS-1:0] below;
	logic [MAX_COLS-1:0] col_mask;
	logic [MAX_COLS-1:0] life_row;
	logic [MAX_COLS-1:0] new_row;
	logic [MAX_COLS-1:0] flip_row;
	logic [MAX_COLS-1:0] wdata;
	logic [MAX_COLS+1:0] ap;
	logic [MAX_COLS+1:0] hp;
	logic [MAX_COLS+1:0] bp;
	logic [RAW-1:0] raddr;
	logic [RAW-1:0] waddr;
	logic rd_go;
	logic below_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= lge_pkg::CFG_RESET;
			cols_cfg_q <= lge_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lge_pkg::REG_ROWS: rows_cfg_q <= cfg_wdata;
				lge_pkg::REG_COLS: cols_cfg_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign rows_ext = NRW'(rows_cfg_q);
	assign cols_ext = NCW'(cols_cfg_q);
	assign nr = (rows_ext > NRW'(MAX_ROWS)) ? NRW'(MAX_ROWS) : rows_ext;
	assign nc = (cols_ext > NCW'(MAX_COLS)) ? NCW'(MAX_COLS) : cols_ext;
	assign nr_c = CW'(nr);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= lge_pkg::op_t'(in_cmd);
			row_q <= in_row;
			col_q <= in_col;
		end
	end

	assign row_ext = NRW'(row_q);
	assign col_ext = NCW'(col_q);
	assign row_idx = row_ext[RAW-1:0];
	assign col_idx = col_ext[CAW-1:0];
	assign oor = (row_ext >= nr) || (col_ext >= nc);

	assign cur_nx = cur_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			cur_q <= '0;
			gen_q <= '0;
			alive_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				sweep_q <= '0;
				cur_q <= '0;
				alive_q <= 1'b0;
			end else begin
				if (cmd.sweep_inc) begin
					sweep_q <= sweep_q + CW'(1);
				end
				if (cmd.advance) begin
					cur_q <= cur_nx;
				end
				if (cmd.alive_set) begin
					alive_q <= rdata_q[col_idx] ^ (op_q == lge_pkg::OP_TOGGLE);
				end
			end
			if (cmd.gen_inc) begin
				gen_q <= gen_q + 32'd1;
			end
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_alive <= alive_q;
			out_gen <= gen_q;
			out_oor <= oor && ((op_q == lge_pkg::OP_TOGGLE) || (op_q == lge_pkg::OP_READ));
		end
	end

	assign m_tvalid = m_valid_q;

	assign raddr = cmd.rd_sweep ? sweep_q[RAW-1:0] : row_idx;
	assign rd_go = cmd.rd_en && (!cmd.rd_sweep || (sweep_q < CW'(MAX_ROWS)));

	always_comb begin
		flip_row = rdata_q;
		flip_row[col_idx] = ~rdata_q[col_idx];
	end

	always_comb begin
		case (cmd.wr_src)
			lge_pkg::WR_LIFE: begin
				waddr = cur_q[RAW-1:0];
				wdata = new_row;
			end
			lge_pkg::WR_FLIP: begin
				waddr = row_idx;
				wdata = flip_row;
			end
			default: begin
				waddr = sweep_q[RAW-1:0];
				wdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			grid_mem[waddr] <= wdata;
		end
		if (rd_go) begin
			rdata_q <= grid_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			above_q <= '0;
			here_q <= rdata_q;
		end else if (cmd.advance) begin
			above_q <= here_q;
			here_q <= rdata_q;
		end
	end

	assign below_ok = cur_nx < nr_c;
	assign below = below_ok ? rdata_q : '0;
	assign ap = {1'b0, above_q & col_mask, 1'b0};
	assign hp = {1'b0, here_q & col_mask, 1'b0};
	assign bp = {1'b0, below & col_mask, 1'b0};

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		assign col_mask[c] = NCW'(c) < nc;
		assign life_row[c] = lge_pkg::life_next(ap[c+2:c], hp[c+2:c], bp[c+2:c]);
	end

	// Columns outside the active area keep their old contents.
	assign new_row = (life_row & col_mask) | (here_q & ~col_mask);

	assign sts.op = op_q;
	assign sts.oor = oor;
	assign sts.nr_zero = (nr == '0);
	assign sts.clr_last = (sweep_q == CW'(MAX_ROWS - 1));
	assign sts.row_last = (cur_nx == nr_c);
	assign sts.out_free = !m_valid_q || m_tready;

endmodule

`default_nettype wire

// File: src/life_grid_generation_engine_top.sv
// Toggle and read: the item is decoded, its grid row is read, the cell is flipped or
// sampled, and the result is loaded. Step: a row sweep reads and writes one grid memory
// row per cycle over the active rows, then the result is loaded; items are taken one at a time.
// No-op, out-of-range address or an area with no rows: the result is loaded after decode.
// Reset is asynchronous and active low; afterwards a clearing pass zeroes every grid
// row while s_tready stays low. Configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module life_grid_generation_engine_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lge_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [lge_pkg::IN_DATA_W-1:0]   s_tdata,  // row[5:0], col[11:6], zero pad
	input  wire logic [1:0]                      s_tuser,  // cmd[1:0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [lge_pkg::OUT_DATA_W-1:0]       m_tdata,  // cell_alive[0], generation[32:1], pad
	output logic                                 m_tuser   // out_of_range
);

	lge_pkg::lge_cmd_t cmd;
	lge_pkg::lge_sts_t sts;
	logic out_alive;
	logic [lge_pkg::GEN_W-1:0] out_gen;

	lge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lge_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_cmd    (s_tuser),
		.in_row    (s_tdata[5:0]),
		.in_col    (s_tdata[11:6]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.out_alive (out_alive),
		.out_gen   (out_gen),
		.out_oor   (m_tuser)
	);

	assign m_tdata = {7'd0, out_gen, out_alive};

endmodule

`default_nettype wire

// File: src/lge_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module lge_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tuser
);

	logic [31:0] last_gen_q;
	logic have_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			last_gen_q <= '0;
		end else if (m_tvalid && m_tready) begin
			have_q <= 1'b1;
			last_gen_q <= m_tdata[32:1];
		end
	end

	// Items are handled one at a time, so an accepted item blocks the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on two consecutive cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[0])
		else $error("out-of-range result reports a live cell");

	// Each item advances the generation by at most one.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && have_q |->
			(m_tdata[32:1] == last_gen_q) || (m_tdata[32:1] == last_gen_q + 32'd1))
		else $error("generation jumped between results");

endmodule

bind life_grid_generation_engine_top lge_chk u_lge_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: verif/life_grid_generation_engine_top_tb.sv
`timescale 1ns / 1ps

module life_grid_generation_engine_top_tb;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 125;
	localparam int NUM_PHASES = 12;
	localparam logic [lge_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [lge_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic [1:0] IDLE_NONE = 2'd0;
	localparam logic [1:0] IDLE_SENDER = 2'd1;
	localparam logic [1:0] IDLE_RECEIVER = 2'd2;
	localparam logic [1:0] IDLE_BOTH = 2'd3;

	typedef struct packed {
		logic alive;
		logic [lge_pkg::GEN_W-1:0] gen;
		logic oor;
	} cell_report_t;

	typedef struct packed {
		lge_pkg::op_t op;
		logic [lge_pkg::ROW_W-1:0] row;
		logic [lge_pkg::COL_W-1:0] col;
		logic typed;
		cell_report_t res;
	} probe_t;

	typedef struct packed {
		logic [lge_pkg::CFG_W-1:0] rows;
		logic [lge_pkg::CFG_W-1:0] cols;
		logic [1:0] idle;
	} area_plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lge_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lge_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [lge_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lge_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
	logic [lge_pkg::GEN_W-1:0] gen_count;
	logic [lge_pkg::CFG_W-1:0] area_rows;
	logic [lge_pkg::CFG_W-1:0] area_cols;

	cell_report_t pending_reports [$];
	int mismatches = 0;
	int cycles = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	life_grid_generation_engine_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int live_rows();
		return (area_rows > GRID_ROWS) ? GRID_ROWS : int'(area_rows);
	endfunction

	function automatic int live_cols();
		return (area_cols > GRID_COLS) ? GRID_COLS : int'(area_cols);
	endfunction

	// All cells of the area move together; neighbors outside the area count as dead.
	function automatic void advance_generation();
		logic [GRID_COLS-1:0] prev [GRID_ROWS];
		int nr;
		int nc;
		int n;
		int rr;
		int cc;
		nr = live_rows();
		nc = live_cols();
		prev = life_grid;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
							n += int'(prev[rr][cc]);
					end
				end
				life_grid[r][c] = (n == 3) || (prev[r][c] && n == 2);
			end
		end
		gen_count = gen_count + lge_pkg::GEN_W'(1);
	endfunction

	function automatic cell_report_t apply_command(lge_pkg::op_t op,
			logic [lge_pkg::ROW_W-1:0] r, logic [lge_pkg::COL_W-1:0] c);
		cell_report_t rep;
		rep = '0;
		case (op)
			lge_pkg::OP_STEP: begin
				advance_generation();
			end
			lge_pkg::OP_TOGGLE, lge_pkg::OP_READ: begin
				if (int'(r) >= live_rows() || int'(c) >= live_cols()) begin
					rep.oor = 1'b1;
				end else begin
					if (op == lge_pkg::OP_TOGGLE)
						life_grid[r][c] = ~life_grid[r][c];
					rep.alive = life_grid[r][c];
				end
			end
			default: begin
			end
		endcase
		rep.gen = gen_count;
		return rep;
	endfunction

	task automatic push_item(input lge_pkg::op_t op, input logic [lge_pkg::ROW_W-1:0] r,
			input logic [lge_pkg::COL_W-1:0] c, input logic typed,
			input cell_report_t typed_rep);
		cell_report_t rep;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0000, c, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rep = apply_command(op, r, c);
		pending_reports.push_back(typed ? typed_rep : rep);
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The two spare indexes take junk data, which the block must ignore.
	task automatic set_area(input logic [lge_pkg::CFG_W-1:0] nrows,
			input logic [lge_pkg::CFG_W-1:0] ncols);
		cfg_we <= 1'b1;
		cfg_index <= lge_pkg::REG_ROWS;
		cfg_wdata <= nrows;
		@(posedge clk);
		cfg_index <= lge_pkg::REG_COLS;
		cfg_wdata <= ncols;
		@(posedge clk);
		cfg_index <= REG_SPARE_A;
		cfg_wdata <= lge_pkg::CFG_W'($urandom);
		@(posedge clk);
		cfg_index <= REG_SPARE_B;
		cfg_wdata <= lge_pkg::CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		area_rows = nrows;
		area_cols = ncols;
	endtask

	task automatic set_idle(input logic [1:0] mode);
		sender_idle_pct = (mode == IDLE_SENDER) ? 60 : (mode == IDLE_BOTH) ? 26 : 0;
		receiver_stall_pct = (mode == IDLE_RECEIVER) ? 60 : (mode == IDLE_BOTH) ? 26 : 0;
	endtask

	// Mostly in-area toggles and reads that keep patterns alive, with steps between them.
	task automatic run_random(input int count, input logic drain_midway);
		int pick;
		lge_pkg::op_t op;
		logic [lge_pkg::ROW_W-1:0] r;
		logic [lge_pkg::COL_W-1:0] c;
		for (int i = 0; i < count; i++) begin
			if (drain_midway && i == count / 2)
				settle_block();
			pick = $urandom_range(99);
			if (pick < 12)
				op = lge_pkg::OP_STEP;
			else if (pick < 16)
				op = lge_pkg::OP_NOP;
			else if (pick < 60)
				op = lge_pkg::OP_TOGGLE;
			else
				op = lge_pkg::OP_READ;
			if ($urandom_range(99) < 80 && live_rows() > 0 && live_cols() > 0) begin
				r = lge_pkg::ROW_W'($urandom_range(live_rows() - 1));
				c = lge_pkg::COL_W'($urandom_range(live_cols() - 1));
			end else begin
				r = lge_pkg::ROW_W'($urandom);
				c = lge_pkg::COL_W'($urandom);
			end
			push_item(op, r, c, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input logic [lge_pkg::GEN_W-1:0] want,
			input logic [lge_pkg::GEN_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cell_report_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_reports.size() == 0) begin
					$error("result item arrived with nothing expected");
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					check_field("cell_alive", lge_pkg::GEN_W'(want.alive),
						lge_pkg::GEN_W'(m_tdata[0]));
					check_field("generation", want.gen, m_tdata[32:1]);
					check_field("out_of_range", lge_pkg::GEN_W'(want.oor),
						lge_pkg::GEN_W'(m_tuser));
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[life_grid_generation_engine_top] ERROR");
			$finish;
		end
	end

	probe_t probes [25] = '{
		'{lge_pkg::OP_READ, 6'd0, 6'd0, 1'b1, '{1'b0, 32'd0, 1'b0}},
		'{lge_pkg::OP_READ, 6'd63, 6'd63, 1'b1, '{1'b0, 32'd0, 1'b0}},
		'{lge_pkg::OP_NOP, 6'd63, 6'd63, 1'b1, '{1'b0, 32'd0, 1'b0}},
		'{lge_pkg::OP_TOGGLE, 6'd0, 6'd0, 1'b1, '{1'b1, 32'd0, 1'b0}},
		'{lge_pkg::OP_TOGGLE, 6'd63, 6'd63, 1'b1, '{1'b1, 32'd0, 1'b0}},
		'{lge_pkg::OP_TOGGLE, 6'd0, 6'd63, 1'b1, '{1'b1, 32'd0, 1'b0}},
		'{lge_pkg::OP_TOGGLE, 6'd63, 6'd0, 1'b1, '{1'b1, 32'd0, 1'b0}},
		'{lge_pkg::OP_STEP, 6'd0, 6'd0, 1'b1, '{1'b0, 32'd1, 1'b0}},
		'{lge_pkg::OP_READ, 6'd0, 6'd0, 1'b1, '{1'b0, 32'd1, 1'b0}},
		'{lge_pkg::OP_TOGGLE, 6'd10, 6'd9, 1'b1, '{1'b1, 32'd1, 1'b0}},
		'{lge_pkg::OP_TOGGLE, 6'd10, 6'd10, 1'b1, '{1'b1, 32'd1, 1'b0}},
		'{lge_pkg::OP_TOGGLE, 6'd10, 6'd11, 1'b1, '{1'b1, 32'd1, 1'b0}},
		'{lge_pkg::OP_STEP, 6'd0, 6'd0, 1'b1, '{1'b0, 32'd2, 1'b0}},
		'{lge_pkg::OP_READ, 6'd9, 6'd10, 1'b0, '0},
		'{lge_pkg::OP_READ, 6'd10, 6'd9, 1'b0, '0},
		'{lge_pkg::OP_READ, 6'd11, 6'd10, 1'b0, '0},
		'{lge_pkg::OP_TOGGLE, 6'd62, 6'd62, 1'b0, '0},
		'{lge_pkg::OP_TOGGLE, 6'd62, 6'd63, 1'b0, '0},
		'{lge_pkg::OP_TOGGLE, 6'd63, 6'd62, 1'b0, '0},
		'{lge_pkg::OP_TOGGLE, 6'd63, 6'd63, 1'b0, '0},
		'{lge_pkg::OP_STEP, 6'd63, 6'd63, 1'b0, '0},
		'{lge_pkg::OP_READ, 6'd63, 6'd63, 1'b0, '0},
		'{lge_pkg::OP_TOGGLE, 6'd5, 6'd5, 1'b0, '0},
		'{lge_pkg::OP_TOGGLE, 6'd5, 6'd5, 1'b0, '0},
		'{lge_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, '0}
	};

	// Oversized, zero and one-wide areas come early; cells left outside a small
	// area are read back once the full area returns.
	area_plan_t plans [NUM_PHASES - 2] = '{
		'{7'd64, 7'd64, IDLE_NONE},
		'{7'd1, 7'd1, IDLE_SENDER},
		'{7'd3, 7'd5, IDLE_RECEIVER},
		'{7'd0, 7'd10, IDLE_BOTH},
		'{7'd127, 7'd100, IDLE_NONE},
		'{7'd10, 7'd0, IDLE_SENDER},
		'{7'd64, 7'd1, IDLE_RECEIVER},
		'{7'd1, 7'd64, IDLE_BOTH},
		'{7'd7, 7'd64, IDLE_NONE},
		'{7'd64, 7'd64, IDLE_BOTH}
	};

	initial begin
		for (int r = 0; r < GRID_ROWS; r++)
			life_grid[r] = '0;
		gen_count = '0;
		area_rows = lge_pkg::CFG_RESET;
		area_cols = lge_pkg::CFG_RESET;
		set_idle(IDLE_NONE);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			push_item(probes[i].op, probes[i].row, probes[i].col, probes[i].typed,
				probes[i].res);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_block();
			if (p < NUM_PHASES - 2) begin
				set_area(plans[p].rows, plans[p].cols);
				set_idle(plans[p].idle);
			end else begin
				set_area(lge_pkg::CFG_W'($urandom_range(1, 64)),
					lge_pkg::CFG_W'($urandom_range(1, 64)));
				set_idle(2'($urandom_range(3)));
			end
			run_random(PHASE_ITEMS, p == 2);
		end

		settle_block();
		if (mismatches == 0) begin
			$display("[life_grid_generation_engine_top] OK");
		end else begin
			$display("[life_grid_generation_engine_top] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
src/lge_pkg.sv
src/lge_ctrl.sv
src/lge_dp.sv
src/life_grid_generation_engine_top.sv
src/lge_chk.sv
verif/life_grid_generation_engine_top_tb.sv
